>>> hdl/chx_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chx_pkg
// Widths, fixed coefficients and shared types of the cubehelix level block.
// ---------------------------------------------------------------------------
package chx_pkg;

    localparam int LEVEL_W  = 8;
    localparam int COLOUR_W = 16;
    localparam int CLIP_W   = 2;
    localparam int SC_W     = 10;
    localparam int ROT_W    = 12;
    localparam int HUE_W    = 10;
    localparam int NL_W     = 9;
    localparam int CFG_W    = 12;
    localparam int CFG_AW   = 2;
    localparam int MSQ_W    = 18;   // (levels-1) squared
    localparam int D_W      = 19;   // 768*(levels-1)
    localparam int NUM_W    = 25;   // offset phase numerator, two's complement sum

    // one quotient bit of each divider per cell
    localparam int DIV_STEPS = 30;
    localparam int PINT_W    = 5;   // integer bits of the phase quotient
    localparam int QP_W      = 25;  // phase quotient bits kept

    localparam logic [CFG_AW-1:0] CFG_START_COLOUR = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ROTATIONS    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HUE_GAIN     = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_NUM_LEVELS   = 2'd3;

    localparam logic [SC_W-1:0]  START_COLOUR_RST = 10'd768;
    localparam logic [ROT_W-1:0] ROTATIONS_RST    = 12'd179;
    localparam logic [HUE_W-1:0] HUE_GAIN_RST     = 10'd256;
    localparam logic [NL_W-1:0]  NUM_LEVELS_RST   = 9'd64;

    localparam logic [30:0] Q30 = 31'h4000_0000;

    // quarter-wave sine polynomial, Q30
    localparam logic [22:0] SIN_A7 = 23'd4858526;
    localparam logic [26:0] SIN_A5 = 27'd85569305;
    localparam logic [29:0] SIN_A3 = 30'd693598668;
    localparam logic [30:0] SIN_A1 = 31'd1686629713;

    // channel mix coefficients, Q16 (cosine term, sine term)
    localparam logic signed [17:0] K_RED_C = -18'sd9739;
    localparam logic signed [17:0] K_RED_S = 18'sd116836;
    localparam logic signed [17:0] K_GRN_C = -18'sd19154;
    localparam logic signed [17:0] K_GRN_S = -18'sd59408;
    localparam logic signed [17:0] K_BLU_C = 18'sd129299;
    localparam logic signed [17:0] K_BLU_S = 18'sd0;

    typedef struct packed {
        logic [MSQ_W-1:0] m_sq;
        logic [D_W-1:0]   d;
    } t_div_const;

    typedef struct packed {
        logic                 gtop;   // index at the last level: intensity is exactly 1
        logic [MSQ_W-1:0]     rg;
        logic [DIV_STEPS-1:0] qg;
        logic [D_W-1:0]       rp;
        logic [PINT_W-1:0]    sh;     // numerator bits still to bring down
        logic [QP_W-1:0]      qp;
    } t_div_data;

endpackage

>>> hdl/chx_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chx_div_cell
// One restoring step of both dividers: intensity and helix phase.
// ---------------------------------------------------------------------------
module chx_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  chx_pkg::t_div_data    i_data,
    input  chx_pkg::t_div_const   i_const,
    output logic                  o_valid,
    output chx_pkg::t_div_data    o_data
);

    logic [chx_pkg::MSQ_W:0] w_rg_sh;
    logic [chx_pkg::MSQ_W:0] w_rg_dif;
    logic [chx_pkg::D_W:0]   w_rp_sh;
    logic [chx_pkg::D_W:0]   w_rp_dif;
    logic                    w_qg;
    logic                    w_qp;
    chx_pkg::t_div_data      n_data;
    chx_pkg::t_div_data      r_data;
    logic                    r_valid;

    always_comb begin
        w_rg_sh  = {i_data.rg, 1'b0};
        w_rg_dif = w_rg_sh - {1'b0, i_const.m_sq};
        w_qg     = (w_rg_sh >= {1'b0, i_const.m_sq});
        w_rp_sh  = {i_data.rp, i_data.sh[chx_pkg::PINT_W-1]};
        w_rp_dif = w_rp_sh - {1'b0, i_const.d};
        w_qp     = (w_rp_sh >= {1'b0, i_const.d});

        n_data    = i_data;
        n_data.rg = w_qg ? w_rg_dif[chx_pkg::MSQ_W-1:0] : w_rg_sh[chx_pkg::MSQ_W-1:0];
        n_data.qg = {i_data.qg[chx_pkg::DIV_STEPS-2:0], w_qg};
        n_data.rp = w_qp ? w_rp_dif[chx_pkg::D_W-1:0] : w_rp_sh[chx_pkg::D_W-1:0];
        n_data.sh = {i_data.sh[chx_pkg::PINT_W-2:0], 1'b0};
        n_data.qp = {i_data.qp[chx_pkg::QP_W-2:0], w_qp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/chx_colour_pipe.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chx_colour_pipe
// Sine/cosine, amplitude, channel mix, clipping and scaling: seven stages.
// ---------------------------------------------------------------------------
module chx_colour_pipe #(
    parameter int COLOUR_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  chx_pkg::t_div_data            i_data,
    input  logic [chx_pkg::HUE_W-1:0]     i_hue_gain,
    output logic                          o_valid,
    output logic [chx_pkg::COLOUR_W-1:0]  o_red,
    output logic [chx_pkg::COLOUR_W-1:0]  o_green,
    output logic [chx_pkg::COLOUR_W-1:0]  o_blue,
    output logic [chx_pkg::CLIP_W-1:0]    o_clip_low,
    output logic [chx_pkg::CLIP_W-1:0]    o_clip_high
);

    localparam int          COL_SHIFT = 30 - COLOUR_BITS;
    localparam logic [30:0] COL_TOP   = 31'((64'd1 << COLOUR_BITS) - 64'd1);

    typedef struct packed {
        logic [chx_pkg::COLOUR_W-1:0] value;
        logic                         lo;
        logic                         hi;
    } t_chan;

    function automatic t_chan chan_out(input logic [30:0] g, input logic [29:0] amp,
                                       input logic signed [34:0] mix);
        logic signed [65:0] prod;
        logic signed [36:0] v;
        logic [30:0]        vc;
        logic [30:0]        sc;
        t_chan              res;
        prod    = $signed({1'b0, amp}) * mix;
        v       = $signed({6'b0, g}) + $signed(prod[65:30]);
        res.lo  = 1'b0;
        res.hi  = 1'b0;
        if (v < 37'sd0) begin
            vc     = '0;
            res.lo = 1'b1;
        end else if (v > $signed({6'b0, chx_pkg::Q30})) begin
            vc     = chx_pkg::Q30;
            res.hi = 1'b1;
        end else begin
            vc = v[30:0];
        end
        sc = vc >> COL_SHIFT;
        if (sc > COL_TOP) begin
            sc = COL_TOP;
        end
        res.value = sc[chx_pkg::COLOUR_W-1:0];
        return res;
    endfunction

    logic [6:0] r_vld;

    // stage 0: quadrant fold and square of the argument
    logic [15:0] w_p;
    logic [15:0] w_x;
    logic [1:0]  w_qs;
    logic [1:0]  w_qc;
    logic [16:0] w_arg_s;
    logic [16:0] w_arg_c;
    logic [33:0] w_sq_s;
    logic [33:0] w_sq_c;
    logic [30:0] w_g;
    logic [30:0] r0_g;
    logic [16:0] r0_arg_s, r0_arg_c, r0_y_s, r0_y_c;
    logic        r0_neg_s, r0_neg_c;

    always_comb begin
        w_g     = i_data.gtop ? chx_pkg::Q30 : {1'b0, i_data.qg};
        w_p     = i_data.qp[24:9];
        w_x     = {w_p[13:0], 2'b00};
        w_qs    = w_p[15:14];
        w_qc    = w_qs + 2'd1;
        w_arg_s = w_qs[0] ? (17'h10000 - {1'b0, w_x}) : {1'b0, w_x};
        w_arg_c = w_qc[0] ? (17'h10000 - {1'b0, w_x}) : {1'b0, w_x};
        w_sq_s  = w_arg_s * w_arg_s;
        w_sq_c  = w_arg_c * w_arg_c;
    end

    // stage 1: innermost Horner step, g*(1-g)
    logic [39:0] w_p1_s, w_p1_c;
    logic [61:0] w_gg;
    logic [26:0] r1_t_s, r1_t_c;
    logic [28:0] r1_ga;
    logic [30:0] r1_g;
    logic [16:0] r1_arg_s, r1_arg_c, r1_y_s, r1_y_c;
    logic        r1_neg_s, r1_neg_c;

    assign w_p1_s = chx_pkg::SIN_A7 * r0_y_s;
    assign w_p1_c = chx_pkg::SIN_A7 * r0_y_c;
    assign w_gg   = r0_g * (chx_pkg::Q30 - r0_g);

    // stage 2
    logic [43:0] w_p2_s, w_p2_c;
    logic [38:0] w_amp;
    logic [29:0] r2_t_s, r2_t_c;
    logic [29:0] r2_amp;
    logic [30:0] r2_g;
    logic [16:0] r2_arg_s, r2_arg_c, r2_y_s, r2_y_c;
    logic        r2_neg_s, r2_neg_c;

    assign w_p2_s = r1_t_s * r1_y_s;
    assign w_p2_c = r1_t_c * r1_y_c;
    assign w_amp  = r1_ga * i_hue_gain;

    // stage 3
    logic [46:0] w_p3_s, w_p3_c;
    logic [30:0] r3_t_s, r3_t_c;
    logic [29:0] r3_amp;
    logic [30:0] r3_g;
    logic [16:0] r3_arg_s, r3_arg_c;
    logic        r3_neg_s, r3_neg_c;

    assign w_p3_s = r2_t_s * r2_y_s;
    assign w_p3_c = r2_t_c * r2_y_c;

    // stage 4: final product, cap at one, quadrant sign
    logic [47:0] w_p4_s, w_p4_c;
    logic [30:0] w_t_s, w_t_c;
    logic signed [31:0] r4_s, r4_c;
    logic [29:0] r4_amp;
    logic [30:0] r4_g;

    always_comb begin
        w_p4_s = r3_t_s * r3_arg_s;
        w_p4_c = r3_t_c * r3_arg_c;
        w_t_s  = (w_p4_s[47:16] > {1'b0, chx_pkg::Q30}) ? chx_pkg::Q30 : w_p4_s[46:16];
        w_t_c  = (w_p4_c[47:16] > {1'b0, chx_pkg::Q30}) ? chx_pkg::Q30 : w_p4_c[46:16];
    end

    // stage 5: channel mix
    logic signed [50:0] w_acc_r, w_acc_g, w_acc_b;
    logic signed [34:0] r5_mix_r, r5_mix_g, r5_mix_b;
    logic [29:0] r5_amp;
    logic [30:0] r5_g;

    assign w_acc_r = chx_pkg::K_RED_C * r4_c + chx_pkg::K_RED_S * r4_s;
    assign w_acc_g = chx_pkg::K_GRN_C * r4_c + chx_pkg::K_GRN_S * r4_s;
    assign w_acc_b = chx_pkg::K_BLU_C * r4_c + chx_pkg::K_BLU_S * r4_s;

    // stage 6: output register
    t_chan w_red, w_grn, w_blu;
    logic [chx_pkg::COLOUR_W-1:0] r6_red, r6_grn, r6_blu;
    logic [chx_pkg::CLIP_W-1:0]   r6_lo, r6_hi;

    always_comb begin
        w_red = chan_out(r5_g, r5_amp, r5_mix_r);
        w_grn = chan_out(r5_g, r5_amp, r5_mix_g);
        w_blu = chan_out(r5_g, r5_amp, r5_mix_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_g     <= w_g;
            r0_arg_s <= w_arg_s;
            r0_arg_c <= w_arg_c;
            r0_y_s   <= w_sq_s[32:16];
            r0_y_c   <= w_sq_c[32:16];
            r0_neg_s <= w_qs[1];
            r0_neg_c <= w_qc[1];

            r1_t_s   <= chx_pkg::SIN_A5 - 27'(w_p1_s[39:16]);
            r1_t_c   <= chx_pkg::SIN_A5 - 27'(w_p1_c[39:16]);
            r1_ga    <= w_gg[58:30];
            r1_g     <= r0_g;
            r1_arg_s <= r0_arg_s;
            r1_arg_c <= r0_arg_c;
            r1_y_s   <= r0_y_s;
            r1_y_c   <= r0_y_c;
            r1_neg_s <= r0_neg_s;
            r1_neg_c <= r0_neg_c;

            r2_t_s   <= chx_pkg::SIN_A3 - 30'(w_p2_s[43:16]);
            r2_t_c   <= chx_pkg::SIN_A3 - 30'(w_p2_c[43:16]);
            r2_amp   <= w_amp[38:9];
            r2_g     <= r1_g;
            r2_arg_s <= r1_arg_s;
            r2_arg_c <= r1_arg_c;
            r2_y_s   <= r1_y_s;
            r2_y_c   <= r1_y_c;
            r2_neg_s <= r1_neg_s;
            r2_neg_c <= r1_neg_c;

            r3_t_s   <= chx_pkg::SIN_A1 - 31'(w_p3_s[46:16]);
            r3_t_c   <= chx_pkg::SIN_A1 - 31'(w_p3_c[46:16]);
            r3_amp   <= r2_amp;
            r3_g     <= r2_g;
            r3_arg_s <= r2_arg_s;
            r3_arg_c <= r2_arg_c;
            r3_neg_s <= r2_neg_s;
            r3_neg_c <= r2_neg_c;

            r4_s     <= r3_neg_s ? -$signed({1'b0, w_t_s}) : $signed({1'b0, w_t_s});
            r4_c     <= r3_neg_c ? -$signed({1'b0, w_t_c}) : $signed({1'b0, w_t_c});
            r4_amp   <= r3_amp;
            r4_g     <= r3_g;

            r5_mix_r <= $signed(w_acc_r[50:16]);
            r5_mix_g <= $signed(w_acc_g[50:16]);
            r5_mix_b <= $signed(w_acc_b[50:16]);
            r5_amp   <= r4_amp;
            r5_g     <= r4_g;

            r6_red   <= w_red.value;
            r6_grn   <= w_grn.value;
            r6_blu   <= w_blu.value;
            r6_lo    <= {1'b0, w_red.lo} + {1'b0, w_grn.lo} + {1'b0, w_blu.lo};
            r6_hi    <= {1'b0, w_red.hi} + {1'b0, w_grn.hi} + {1'b0, w_blu.hi};
        end
    end

    assign o_valid     = r_vld[6];
    assign o_red       = r6_red;
    assign o_green     = r6_grn;
    assign o_blue      = r6_blu;
    assign o_clip_low  = r6_lo;
    assign o_clip_high = r6_hi;

endmodule

>>> hdl/cubehelix_colour_level_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cubehelix_colour_level_top
// Cubehelix colour of one table level: divider cell chain, then colour pipe.
// ---------------------------------------------------------------------------
//  channel   direction  width  content
//  s_axis    in         8      level_index
//  m_axis    out        56     red, green, blue, clip_low_count, clip_high_count
//  cfg       in         2+12   register index, write data
//
//  One level per clock while results are taken. Stages: input stage, 30 divider cells
//  (one quotient bit of intensity and of phase per cell), 7 colour stages.
//  Synchronous active-low reset clears the valid bits and loads the
//  register defaults. When a result is not taken the whole pipeline holds.
// ---------------------------------------------------------------------------
module cubehelix_colour_level_top #(
    parameter int MAX_LEVELS  = 256,
    parameter int COLOUR_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] level_index
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] red_value, [31:16] green_value, [47:32] blue_value,
    // [49:48] clip_low_count, [51:50] clip_high_count, [55:52] zero
    output logic [55:0]                       m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [chx_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [chx_pkg::CFG_W-1:0]         i_cfg_wdata
);

    localparam int STEPS = chx_pkg::DIV_STEPS;

    logic [chx_pkg::SC_W-1:0]         r_start_colour;
    logic signed [chx_pkg::ROT_W-1:0] r_rotations;
    logic [chx_pkg::HUE_W-1:0]        r_hue_gain;
    logic [chx_pkg::NL_W-1:0]         r_num_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_colour <= chx_pkg::START_COLOUR_RST;
            r_rotations    <= chx_pkg::ROTATIONS_RST;
            r_hue_gain     <= chx_pkg::HUE_GAIN_RST;
            r_num_levels   <= chx_pkg::NUM_LEVELS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                chx_pkg::CFG_START_COLOUR: r_start_colour <= i_cfg_wdata[chx_pkg::SC_W-1:0];
                chx_pkg::CFG_ROTATIONS:    r_rotations    <= i_cfg_wdata;
                chx_pkg::CFG_HUE_GAIN:     r_hue_gain     <= i_cfg_wdata[chx_pkg::HUE_W-1:0];
                chx_pkg::CFG_NUM_LEVELS:   r_num_levels   <= i_cfg_wdata[chx_pkg::NL_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage: clamp, square of the index, offset phase numerator
    logic [chx_pkg::NL_W-1:0]   w_n;
    logic [chx_pkg::NL_W-1:0]   w_m;
    logic [7:0]                 w_i;
    logic [15:0]                w_i_sq;
    logic [chx_pkg::D_W-1:0]    w_d;
    logic [18:0]                w_sc_m;
    logic signed [20:0]         w_rot_i;
    logic [chx_pkg::NUM_W-1:0]  w_num;
    logic                       w_en;
    logic                       w_gtop;
    chx_pkg::t_div_const        r_div_const;
    chx_pkg::t_div_data         n_front;
    chx_pkg::t_div_data         r_front;
    logic                       r_front_valid;

    always_comb begin
        if (r_num_levels < 9'd2) begin
            w_n = 9'd2;
        end else if ({23'b0, r_num_levels} > 32'(MAX_LEVELS)) begin
            w_n = (chx_pkg::NL_W)'(MAX_LEVELS);
        end else begin
            w_n = r_num_levels;
        end
        w_m     = w_n - 9'd1;
        w_i     = ({1'b0, s_axis_tdata} > w_m) ? w_m[7:0] : s_axis_tdata;
        w_gtop  = ({1'b0, w_i} == w_m);
        w_i_sq  = w_i * w_i;
        w_d     = 19'({w_m, 9'b0}) + 19'({w_m, 8'b0});
        w_sc_m  = r_start_colour * w_m;
        w_rot_i = r_rotations * $signed({1'b0, w_i});
        // add 16 turns so the numerator stays positive
        w_num   = {6'b0, w_sc_m} + 25'(w_rot_i) + 25'(w_rot_i) + 25'(w_rot_i)
                + {2'b0, w_d, 4'b0};

        n_front      = '0;
        n_front.gtop = w_gtop;
        n_front.rg   = w_gtop ? '0 : {2'b0, w_i_sq};
        n_front.rp   = w_num[23:5];
        n_front.sh   = w_num[4:0];
    end

    always_ff @(posedge i_clk) begin
        r_div_const.m_sq <= w_m * w_m;
        r_div_const.d    <= w_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (w_en) begin
            r_front_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    // divider cell chain
    logic [STEPS:0]     w_cv;
    chx_pkg::t_div_data w_cd [STEPS+1];

    assign w_cv[0] = r_front_valid;
    assign w_cd[0] = r_front;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        chx_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[k]),
            .i_data  (w_cd[k]),
            .i_const (r_div_const),
            .o_valid (w_cv[k+1]),
            .o_data  (w_cd[k+1])
        );
    end

    logic                          w_out_valid;
    logic [chx_pkg::COLOUR_W-1:0]  w_red, w_green, w_blue;
    logic [chx_pkg::CLIP_W-1:0]    w_lo, w_hi;

    chx_colour_pipe #(
        .COLOUR_BITS (COLOUR_BITS)
    ) u_colour (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_cv[STEPS]),
        .i_data      (w_cd[STEPS]),
        .i_hue_gain  (r_hue_gain),
        .o_valid     (w_out_valid),
        .o_red       (w_red),
        .o_green     (w_green),
        .o_blue      (w_blue),
        .o_clip_low  (w_lo),
        .o_clip_high (w_hi)
    );

    // advance unless a result waits on a stalled sink
    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {4'b0, w_hi, w_lo, w_blue, w_green, w_red};

endmodule

>>> hdl/chx_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chx_checker
// Port-level checks of the cubehelix level block, bound to the top level.
// ---------------------------------------------------------------------------
module chx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a channel clips one way at most
    a_clip_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[49:48]} + {1'b0, m_axis_tdata[51:50]}) <= 3'd3)
        else $error("clip counts exceed channel count");

    a_all_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[49:48] == 2'd3 |-> m_axis_tdata[47:0] == 48'd0)
        else $error("all channels clipped low but colour not black");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind cubehelix_colour_level_top chx_checker u_chx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
